### sv/sparse_dot_score_fusion_macros.svh
// Assertion macros for the sparse dot score fusion block.
// Expects clk and rst_n in the scope of use.
`ifndef SPARSE_DOT_SCORE_FUSION_MACROS_SVH
`define SPARSE_DOT_SCORE_FUSION_MACROS_SVH

// same-cycle implication
`define SDSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SDSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/sdsf_pkg.sv
// Shared types, constants and tables for the sparse dot score fusion block.
// No dependencies.
`default_nettype none
package sdsf_pkg;

  localparam int FEATURE_DEPTH = 65536;
  localparam int ADDR_W        = $clog2(FEATURE_DEPTH);
  localparam int VALUE_BITS    = 16;
  localparam int ACC_W         = 34;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [15:0] Q_ONE = 16'h8000;
  localparam logic [15:0] ALPHA_RESET = 16'h4000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FUSION_EXP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd1;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_ACC      = 2'd1,
    OP_ACC_LAST = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] idx;
    logic [15:0] val;
    logic [15:0] base;
  } qitem_t;

  typedef struct packed {
    logic [15:0] dot;
    logic [15:0] base;
    logic [15:0] alpha;
  } fuse_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] fused;
  } fuse_sts_t;

  typedef logic [31:0] exp_tab_t [16];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'h1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > x) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-i), i = 1..16, Q2.30, each the integer square root of the previous
  function automatic exp_tab_t exp_tab_f();
    logic [63:0] c;
    exp_tab_t    t;
    c = 64'h1 << 31;
    for (int i = 0; i < 16; i++) begin
      c = isqrt64(c << 30);
      t[i] = c[31:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_tab_f();

endpackage
`default_nettype wire

### sv/sdsf_if.sv
// Channel interfaces: input requests, results, configuration writes.
// Uses no package.
`default_nettype none
interface sdsf_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] feature_index;
  logic [15:0] entry_value;
  logic [15:0] base_score;
  logic        last_entry;
  modport source (output valid, req_type, feature_index, entry_value, base_score,
                  last_entry, input ready);
  modport sink (input valid, req_type, feature_index, entry_value, base_score,
                last_entry, output ready);
endinterface

interface sdsf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fused_score;
  logic [15:0] raw_dot;
  logic        below_threshold;
  modport source (output valid, fused_score, raw_dot, below_threshold, input ready);
  modport sink (input valid, fused_score, raw_dot, below_threshold, output ready);
endinterface

interface sdsf_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/sdsf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module sdsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### sv/sdsf_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on sdsf_pkg and sdsf_if.
`default_nettype none
module sdsf_front import sdsf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  sdsf_in_if.sink  in_ch,
  input  logic     hold,
  input  logic     pop,
  output qitem_t   head,
  output logic     nonempty
);
  qitem_t              q_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                push;
  qitem_t              item;

  always_comb begin
    item.op   = !in_ch.req_type ? OP_WRITE : (in_ch.last_entry ? OP_ACC_LAST : OP_ACC);
    item.idx  = in_ch.feature_index;
    item.val  = in_ch.entry_value;
    item.base = in_ch.base_score;
  end

  assign in_ch.ready = !hold && (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign nonempty    = (cnt_r != '0);
  assign head        = q_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= item;
  end
endmodule
`default_nettype wire

### sv/sdsf_fuse.sv
// Fusion unit: base^alpha * dot^(1-alpha) via iterative log2 and exp2, Q1.15.
// Depends on sdsf_pkg (exp2 constant table).
`default_nettype none
module sdsf_fuse import sdsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  fuse_req_t req,
  output fuse_sts_t sts
);
  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_LOGB = 7'b0000010,
    F_LOGD = 7'b0000100,
    F_MIX1 = 7'b0001000,
    F_MIX2 = 7'b0010000,
    F_EXP  = 7'b0100000,
    F_RND  = 7'b1000000
  } fstate_t;

  fstate_t      state_r, state_nxt;
  logic [30:0]  m_r, m_nxt;
  logic [3:0]   p_r, p_nxt;
  logic [15:0]  frac_r, frac_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic [19:0]  nlb_r, nlb_nxt, nld_r, nld_nxt;
  logic [15:0]  alpha_r, alpha_nxt, dot_r, dot_nxt;
  logic [35:0]  prod_r, prod_nxt;
  logic [19:0]  mag_r, mag_nxt;
  logic [31:0]  r_r, r_nxt;
  logic [15:0]  fused_r, fused_nxt;
  logic         done_r, done_nxt;

  logic [61:0]  sq;
  logic [31:0]  sq_sh;
  logic [15:0]  frac_step;
  logic [30:0]  m_step;
  logic [19:0]  nl_val;
  logic [15:0]  ld_x;
  logic [3:0]   ld_p;
  logic [30:0]  ld_m;
  logic [16:0]  beta;
  logic [35:0]  mix_sum;
  logic [15:0]  g;
  logic [63:0]  eprod;
  logic [4:0]   shift;
  logic [32:0]  rsum, rres;

  // leading one of the operand picks the integer part of the log
  always_comb begin
    ld_p = '0;
    for (int i = 1; i < 16; i++) begin
      if (ld_x[i]) ld_p = 4'(i);
    end
    ld_m = 31'(ld_x) << (5'd30 - 5'(ld_p));
  end

  // one squaring step of the log2 mantissa
  always_comb begin
    sq        = 62'(m_r) * 62'(m_r);
    sq_sh     = sq[61:30];
    frac_step = {frac_r[14:0], sq_sh[31]};
    m_step    = sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
    nl_val    = {4'd15 - p_r, 16'h0000} - 20'(frac_step);
  end

  always_comb begin
    beta    = 17'h08000 - 17'(alpha_r);
    mix_sum = prod_r + 36'(beta) * 36'(nld_r);
    g       = ~mag_r[15:0] + 16'd1;
    eprod   = 64'(r_r) * 64'(EXP_TAB[cnt_r]);
    shift   = 5'(mag_r[19:16]) + 5'(mag_r[15:0] != 16'h0000);
    rsum    = 33'(r_r) + (33'd1 << (5'd14 + shift));
    rres    = rsum >> (5'd15 + shift);
  end

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    p_nxt     = p_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    nlb_nxt   = nlb_r;
    nld_nxt   = nld_r;
    alpha_nxt = alpha_r;
    dot_nxt   = dot_r;
    prod_nxt  = prod_r;
    mag_nxt   = mag_r;
    r_nxt     = r_r;
    fused_nxt = fused_r;
    done_nxt  = 1'b0;
    ld_x      = dot_r;
    case (state_r)
      F_IDLE: begin
        // zero base only reaches here with alpha zero: log taken as 0
        ld_x = (req.base == 16'h0000) ? Q_ONE : req.base;
        if (start) begin
          alpha_nxt = req.alpha;
          dot_nxt   = req.dot;
          m_nxt     = ld_m;
          p_nxt     = ld_p;
          frac_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = F_LOGB;
        end
      end
      F_LOGB: begin
        m_nxt    = m_step;
        frac_nxt = frac_step;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          nlb_nxt   = nl_val;
          m_nxt     = ld_m;
          p_nxt     = ld_p;
          frac_nxt  = '0;
          state_nxt = F_LOGD;
        end
      end
      F_LOGD: begin
        m_nxt    = m_step;
        frac_nxt = frac_step;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          nld_nxt   = nl_val;
          state_nxt = F_MIX1;
        end
      end
      F_MIX1: begin
        prod_nxt  = 36'(alpha_r) * 36'(nlb_r);
        state_nxt = F_MIX2;
      end
      F_MIX2: begin
        // exponent magnitude stays at most 15 * 2^16, so 2^-E never underflows early
        mag_nxt   = mix_sum[34:15];
        r_nxt     = 32'h4000_0000;
        cnt_nxt   = '0;
        state_nxt = F_EXP;
      end
      F_EXP: begin
        if (g[4'd15 - cnt_r]) r_nxt = eprod[61:30];
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = F_RND;
      end
      F_RND: begin
        fused_nxt = (rres > 33'(Q_ONE)) ? Q_ONE : rres[15:0];
        done_nxt  = 1'b1;
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    p_r     <= p_nxt;
    frac_r  <= frac_nxt;
    cnt_r   <= cnt_nxt;
    nlb_r   <= nlb_nxt;
    nld_r   <= nld_nxt;
    alpha_r <= alpha_nxt;
    dot_r   <= dot_nxt;
    prod_r  <= prod_nxt;
    mag_r   <= mag_nxt;
    r_r     <= r_nxt;
    fused_r <= fused_nxt;
  end

  assign sts.done  = done_r;
  assign sts.fused = fused_r;
endmodule
`default_nettype wire

### sv/sdsf_back.sv
// Back end: weight memory, clearing pass, dot accumulation, result register.
// Depends on sdsf_pkg, sdsf_if, sdsf_ram, sdsf_fuse and the assertion macros.
`default_nettype none
`include "sparse_dot_score_fusion_macros.svh"
module sdsf_back import sdsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sdsf_cfg_if.sink    cfg_ch,
  sdsf_out_if.source  out_ch,
  input  qitem_t      head,
  input  logic        nonempty,
  output logic        pop,
  output logic        clearing
);
  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_FIN  = 6'b001000,
    S_WAIT = 6'b010000,
    S_OUT  = 6'b100000
  } bstate_t;

  bstate_t           state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  qitem_t            cur_r, cur_nxt;
  logic [15:0]       alpha_cfg_r, thr_r;
  logic [15:0]       res_fused_r, res_fused_nxt, res_dot_r, res_dot_nxt;
  logic              res_below_r, res_below_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_fused_r, out_dot_r;
  logic              out_below_r;
  logic              out_load;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_addr;
  logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;

  logic [15:0] w;
  logic [31:0] wprod;
  logic [ACC_W:0] sum;
  logic [15:0] dot, alpha, base;
  logic        below, zero_path;
  logic        fu_start;
  fuse_req_t   fu_req;
  fuse_sts_t   fu_sts;

  sdsf_ram #(.WIDTH(VALUE_BITS), .DEPTH(FEATURE_DEPTH)) u_wmem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  sdsf_fuse u_fuse (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fu_start),
    .req   (fu_req),
    .sts   (fu_sts)
  );

  assign cfg_ch.ready = 1'b1;
  assign clearing     = (state_r == S_CLR);

  always_comb begin
    w     = (32'(cur_r.idx) < FEATURE_DEPTH) ? ram_rdata : '0;
    wprod = 32'(w) * 32'(cur_r.val);
    sum   = {1'b0, acc_r} + (ACC_W+1)'(wprod[31:15]);
    dot   = (acc_r > ACC_W'(Q_ONE)) ? Q_ONE : acc_r[15:0];
    below = (dot <= thr_r);
    alpha = (alpha_cfg_r > Q_ONE) ? Q_ONE : alpha_cfg_r;
    base  = (cur_r.base > Q_ONE) ? Q_ONE : cur_r.base;
    zero_path    = below || (dot == 16'h0000) || (base == 16'h0000 && alpha != 16'h0000);
    fu_req.dot   = dot;
    fu_req.base  = base;
    fu_req.alpha = alpha;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    acc_nxt       = acc_r;
    cur_nxt       = cur_r;
    res_fused_nxt = res_fused_r;
    res_dot_nxt   = res_dot_r;
    res_below_nxt = res_below_r;
    ram_we        = 1'b0;
    ram_addr      = head.idx[ADDR_W-1:0];
    ram_wdata     = head.val[VALUE_BITS-1:0];
    pop           = 1'b0;
    fu_start      = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (nonempty) begin
          pop     = 1'b1;
          cur_nxt = head;
          case (head.op)
            OP_WRITE:    ram_we = (32'(head.idx) < FEATURE_DEPTH);
            OP_ACC:      state_nxt = S_RD;
            OP_ACC_LAST: state_nxt = S_RD;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        acc_nxt   = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
        state_nxt = (cur_r.op == OP_ACC_LAST) ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        acc_nxt       = '0;
        res_dot_nxt   = dot;
        res_below_nxt = below;
        res_fused_nxt = '0;
        if (zero_path) begin
          state_nxt = S_OUT;
        end else begin
          fu_start  = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (fu_sts.done) begin
          res_fused_nxt = fu_sts.fused;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      alpha_cfg_r <= ALPHA_RESET;
      thr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_FUSION_EXP: alpha_cfg_r <= cfg_ch.data;
          REG_THRESHOLD:  thr_r       <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    res_fused_r <= res_fused_nxt;
    res_dot_r   <= res_dot_nxt;
    res_below_r <= res_below_nxt;
    if (out_load) begin
      out_fused_r <= res_fused_r;
      out_dot_r   <= res_dot_r;
      out_below_r <= res_below_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.fused_score     = out_fused_r;
  assign out_ch.raw_dot         = out_dot_r;
  assign out_ch.below_threshold = out_below_r;

  `SDSF_ASSERT_IMP(a_below_gives_zero, out_valid_r && out_below_r, out_fused_r == 16'h0000, "fused score nonzero below threshold")
  `SDSF_ASSERT_IMP(a_done_in_wait, fu_sts.done, state_r == S_WAIT, "fusion result with no request waiting")
  `SDSF_ASSERT_NXT(a_rd_follow, state_r == S_RD, state_r == S_IDLE || state_r == S_FIN, "bad step after weight read")
  `SDSF_ASSERT_IMP(a_no_pop_clear, state_r == S_CLR, !pop, "request taken during clearing pass")
endmodule
`default_nettype wire

### sv/sparse_dot_score_fusion.sv
// Top level of the sparse dot score fusion block: front queue plus back engine.
// Depends on sdsf_pkg, sdsf_if, sdsf_front, sdsf_back.
//
//   channel   dir   handshake          payload
//   in_ch     in    valid/ready        req_type feature_index entry_value base_score last_entry
//   out_ch    out   valid/ready        fused_score raw_dot below_threshold
//   cfg_ch    in    valid/ready(=1)    index data
//
// After reset a clearing pass zeroes the weight memory, with in_ch.ready held low.
// Back end takes one queued request at a time: a weight write, an accumulate (memory
// read, then multiply-add), or a last entry, which also builds the result and may run
// the fusion unit (two 16-step log2 loops, one 16-step exp2 loop).
// A 4-deep queue keeps accepting requests while the back end works or out_ch stalls.
`default_nettype none
module sparse_dot_score_fusion import sdsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sdsf_in_if.sink    in_ch,
  sdsf_out_if.source out_ch,
  sdsf_cfg_if.sink   cfg_ch
);
  qitem_t head;
  logic   nonempty;
  logic   pop;
  logic   clearing;

  sdsf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .hold     (clearing),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty)
  );

  sdsf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_ch   (cfg_ch),
    .out_ch   (out_ch),
    .head     (head),
    .nonempty (nonempty),
    .pop      (pop),
    .clearing (clearing)
  );
endmodule
`default_nettype wire
